### rtl/core/erfp_pkg.sv
package erfp_pkg;

  localparam int unsigned POSITION_WIDTH_DEF = 16;
  localparam int unsigned HEADER_END = 22;
  localparam int unsigned FCS_BYTES = 4;
  localparam int unsigned MIN_FRAME_BYTES = 26;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] PREAMBLE_BYTE = 8'h55;
  localparam logic [7:0] SFD_BYTE = 8'hd5;
  localparam logic [31:0] CRC_PRESET = 32'hffffffff;
  localparam logic [31:0] CRC_GEN_REFL = 32'hedb88320;
  localparam logic [31:0] CRC_GOOD_RESIDUE = 32'hdebb20e3;
  localparam logic [47:0] BROADCAST_MAC = 48'hffffffffffff;

  typedef enum logic [1:0] {
    STATUS_ACCEPTED = 2'd0,
    STATUS_FCS_BAD  = 2'd1,
    STATUS_ADDR_MISMATCH = 2'd2,
    STATUS_RUNT     = 2'd3
  } frame_status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic        run_last;
    logic [1:0]  frame_status;
    logic        preamble_good;
    logic [47:0] dest_address;
    logic [47:0] source_address;
    logic [15:0] frame_type;
    logic [31:0] crc_residue;
  } out_word_t;

  typedef struct packed {
    logic [1:0] count;
    out_word_t  word_a;
    out_word_t  word_b;
  } queue_push_t;

endpackage

### rtl/core/erfp_out_queue.sv
module erfp_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  erfp_pkg::queue_push_t push,
  output logic                room_two,
  output logic                out_valid,
  input  logic                out_stall,
  output erfp_pkg::out_word_t out_data
);
  import erfp_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  out_word_t slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] tail_p1;
  logic pop;

  assign pop = out_valid && !out_stall;
  assign tail_p1 = tail_r + PTR_W'(1);
  assign head_nxt = pop ? head_r + PTR_W'(1) : head_r;
  assign tail_nxt = tail_r + PTR_W'(push.count);
  assign count_nxt = count_r + CNT_W'(push.count) - CNT_W'(pop);

  assign out_valid = (count_r != '0);
  assign out_data = slot_r[head_r];
  assign room_two = (count_r <= CNT_W'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      count_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slot_r[tail_r] <= push.word_a;
    end
    if (push.count == 2'd2) begin
      slot_r[tail_p1] <= push.word_b;
    end
  end

endmodule

### rtl/core/ethernet_rx_frame_parser_unit.sv
// Ethernet receive parser: takes one frame byte per word, preamble and SFD first, and
// can accept a byte every cycle while in_stall is low. Each byte updates the preamble check,
// the reflected CRC-32 (from byte 8 on) and the header captures in the same cycle it is
// accepted; bytes from position 22 on run through a four-byte delay so the FCS never leaves
// the block. Results go into a four-word output queue: each byte from position 26 on pushes
// a payload word with the byte four positions before it, and the final byte of a frame
// yields its last payload word (if any) followed by a status word with the captured
// addresses, ethertype, CRC residue and status (runt, FCS bad, address mismatch, accepted).
// in_stall rises only when the queue lacks room for two words, i.e. when out_stall backs
// up. own_mac is written through cfg_we/cfg_wdata; the user must write it between frames,
// which the block does not enforce. The byte counter is POSITION_WIDTH bits and saturates.
module ethernet_rx_frame_parser_unit #(
  parameter int unsigned POSITION_WIDTH = erfp_pkg::POSITION_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  erfp_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output erfp_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [47:0]         cfg_wdata
);
  import erfp_pkg::*;

  localparam logic [POSITION_WIDTH-1:0] POS_SFD = POSITION_WIDTH'(7);
  localparam logic [POSITION_WIDTH-1:0] POS_DEST = POSITION_WIDTH'(8);
  localparam logic [POSITION_WIDTH-1:0] POS_SRC = POSITION_WIDTH'(14);
  localparam logic [POSITION_WIDTH-1:0] POS_TYPE = POSITION_WIDTH'(20);
  localparam logic [POSITION_WIDTH-1:0] POS_HDR_END = POSITION_WIDTH'(HEADER_END);
  localparam logic [POSITION_WIDTH-1:0] POS_PAY =
    POSITION_WIDTH'(HEADER_END + FCS_BYTES);
  localparam logic [POSITION_WIDTH-1:0] POS_RUNT = POSITION_WIDTH'(MIN_FRAME_BYTES - 1);
  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] v;
    v = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_GEN_REFL) : (v >> 1);
    end
    return v;
  endfunction

  logic [47:0] own_mac_r;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        pre_r, pre_nxt;
  logic [47:0] dest_r, dest_nxt;
  logic [47:0] src_r, src_nxt;
  logic [15:0] type_r, type_nxt;
  logic [7:0]  dly_r [FCS_BYTES];
  logic [7:0]  dly_nxt [FCS_BYTES];

  logic        accept;
  logic        room_two;
  logic [7:0]  b;
  logic        emit_pay;
  logic [1:0]  status;
  out_word_t   pay_word, stat_word;
  queue_push_t push;

  assign accept = in_valid && !in_stall;
  assign in_stall = !room_two;
  assign b = in_data.data_byte;

  always_comb begin
    pre_nxt = pre_r;
    crc_nxt = crc_r;
    dest_nxt = dest_r;
    src_nxt = src_r;
    type_nxt = type_r;
    dly_nxt = dly_r;

    if (pos_r < POS_DEST) begin
      if (b != ((pos_r == POS_SFD) ? SFD_BYTE : PREAMBLE_BYTE)) begin
        pre_nxt = 1'b0;
      end
    end else begin
      crc_nxt = crc_byte(crc_r, b);
    end

    if (pos_r >= POS_DEST && pos_r < POS_SRC) begin
      dest_nxt = {dest_r[39:0], b};
    end else if (pos_r >= POS_SRC && pos_r < POS_TYPE) begin
      src_nxt = {src_r[39:0], b};
    end else if (pos_r >= POS_TYPE && pos_r < POS_HDR_END) begin
      type_nxt = {type_r[7:0], b};
    end

    if (pos_r >= POS_HDR_END) begin
      for (int i = FCS_BYTES - 1; i > 0; i--) begin
        dly_nxt[i] = dly_r[i-1];
      end
      dly_nxt[0] = b;
    end

    emit_pay = (pos_r >= POS_PAY);

    if (pos_r < POS_RUNT) begin
      status = STATUS_RUNT;
    end else if (crc_nxt != CRC_GOOD_RESIDUE) begin
      status = STATUS_FCS_BAD;
    end else if (dest_nxt != own_mac_r && dest_nxt != BROADCAST_MAC) begin
      status = STATUS_ADDR_MISMATCH;
    end else begin
      status = STATUS_ACCEPTED;
    end

    pay_word = '0;
    pay_word.item_kind = KIND_PAYLOAD;
    pay_word.payload_byte = dly_r[FCS_BYTES-1];

    stat_word = '0;
    stat_word.item_kind = KIND_STATUS;
    stat_word.run_last = 1'b1;
    stat_word.frame_status = status;
    stat_word.preamble_good = pre_nxt && (pos_r >= POS_SFD);
    stat_word.dest_address = dest_nxt;
    stat_word.source_address = src_nxt;
    stat_word.frame_type = type_nxt;
    stat_word.crc_residue = crc_nxt;

    push.count = '0;
    if (accept) begin
      push.count = 2'(emit_pay) + 2'(in_data.last_byte);
    end
    push.word_a = emit_pay ? pay_word : stat_word;
    push.word_b = stat_word;

    if (in_data.last_byte) begin
      pos_nxt = '0;
    end else if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + POSITION_WIDTH'(1);
    end else begin
      pos_nxt = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r <= '0;
    end else if (cfg_we) begin
      own_mac_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= CRC_PRESET;
      pre_r <= 1'b1;
      dest_r <= '0;
      src_r <= '0;
      type_r <= '0;
      for (int i = 0; i < FCS_BYTES; i++) begin
        dly_r[i] <= '0;
      end
    end else if (accept) begin
      pos_r <= pos_nxt;
      if (in_data.last_byte) begin
        crc_r <= CRC_PRESET;
        pre_r <= 1'b1;
        dest_r <= '0;
        src_r <= '0;
        type_r <= '0;
        for (int i = 0; i < FCS_BYTES; i++) begin
          dly_r[i] <= '0;
        end
      end else begin
        crc_r <= crc_nxt;
        pre_r <= pre_nxt;
        dest_r <= dest_nxt;
        src_r <= src_nxt;
        type_r <= type_nxt;
        dly_r <= dly_nxt;
      end
    end
  end

  erfp_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room_two  (room_two),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### verif/erfp_frame_checker.sv
`timescale 1ns / 100ps

module erfp_frame_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  erfp_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  erfp_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [47:0]         cfg_wdata,
  output int                  fail_count,
  output int                  open_count
);
  import erfp_pkg::*;

  logic [POSITION_WIDTH_DEF-1:0] byte_pos;
  logic [31:0] crc_reg;
  logic        pre_ok;
  logic [47:0] dst_cap;
  logic [47:0] src_cap;
  logic [15:0] type_cap;
  logic [7:0]  fcs_dly [4];
  logic [47:0] station_mac;
  out_word_t   parsed_words [$];
  int          mismatches = 0;
  int          waiting = 0;

  assign fail_count = mismatches;
  assign open_count = waiting;

  function automatic logic [31:0] crc_update(logic [31:0] crc, logic [7:0] b);
    logic [31:0] v;
    v = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_GEN_REFL) : (v >> 1);
    end
    return v;
  endfunction

  task automatic clear_frame();
    byte_pos = '0;
    crc_reg = CRC_PRESET;
    pre_ok = 1'b1;
    dst_cap = '0;
    src_cap = '0;
    type_cap = '0;
    for (int k = 0; k < 4; k++) begin
      fcs_dly[k] = '0;
    end
  endtask

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic parse_byte(in_word_t w);
    out_word_t     res;
    frame_status_t st;
    int unsigned   pos;
    pos = 32'(byte_pos);
    if (pos < 8) begin
      if (w.data_byte != ((pos == 7) ? SFD_BYTE : PREAMBLE_BYTE)) pre_ok = 1'b0;
    end else begin
      crc_reg = crc_update(crc_reg, w.data_byte);
    end
    if (pos >= 8 && pos < 14) begin
      dst_cap = {dst_cap[39:0], w.data_byte};
    end else if (pos >= 14 && pos < 20) begin
      src_cap = {src_cap[39:0], w.data_byte};
    end else if (pos >= 20 && pos < HEADER_END) begin
      type_cap = {type_cap[7:0], w.data_byte};
    end
    if (pos >= HEADER_END) begin
      if (pos >= HEADER_END + FCS_BYTES) begin
        res = '0;
        res.item_kind = KIND_PAYLOAD;
        res.payload_byte = fcs_dly[3];
        parsed_words.insert(parsed_words.size(), res);
      end
      fcs_dly[3] = fcs_dly[2];
      fcs_dly[2] = fcs_dly[1];
      fcs_dly[1] = fcs_dly[0];
      fcs_dly[0] = w.data_byte;
    end
    if (w.last_byte) begin
      if (pos < MIN_FRAME_BYTES - 1) st = STATUS_RUNT;
      else if (crc_reg != CRC_GOOD_RESIDUE) st = STATUS_FCS_BAD;
      else if (dst_cap != station_mac && dst_cap != BROADCAST_MAC) st = STATUS_ADDR_MISMATCH;
      else st = STATUS_ACCEPTED;
      res = '0;
      res.item_kind = KIND_STATUS;
      res.run_last = 1'b1;
      res.frame_status = st;
      res.preamble_good = pre_ok && (pos >= 7);
      res.dest_address = dst_cap;
      res.source_address = src_cap;
      res.frame_type = type_cap;
      res.crc_residue = crc_reg;
      parsed_words.insert(parsed_words.size(), res);
      clear_frame();
    end else if (byte_pos != '1) begin
      byte_pos = byte_pos + POSITION_WIDTH_DEF'(1);
    end
  endtask

  task automatic check_word(out_word_t got);
    out_word_t want;
    if (parsed_words.size() == 0) begin
      flag_mismatch("word with nothing pending", 64'(got.item_kind), 64'(0));
      return;
    end
    want = parsed_words.pop_front();
    if (got.item_kind !== want.item_kind)
      flag_mismatch("item_kind", 64'(got.item_kind), 64'(want.item_kind));
    if (got.payload_byte !== want.payload_byte)
      flag_mismatch("payload_byte", 64'(got.payload_byte), 64'(want.payload_byte));
    if (got.run_last !== want.run_last)
      flag_mismatch("run_last", 64'(got.run_last), 64'(want.run_last));
    if (got.frame_status !== want.frame_status)
      flag_mismatch("frame_status", 64'(got.frame_status), 64'(want.frame_status));
    if (got.preamble_good !== want.preamble_good)
      flag_mismatch("preamble_good", 64'(got.preamble_good), 64'(want.preamble_good));
    if (got.dest_address !== want.dest_address)
      flag_mismatch("dest_address", 64'(got.dest_address), 64'(want.dest_address));
    if (got.source_address !== want.source_address)
      flag_mismatch("source_address", 64'(got.source_address), 64'(want.source_address));
    if (got.frame_type !== want.frame_type)
      flag_mismatch("frame_type", 64'(got.frame_type), 64'(want.frame_type));
    if (got.crc_residue !== want.crc_residue)
      flag_mismatch("crc_residue", 64'(got.crc_residue), 64'(want.crc_residue));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      station_mac = '0;
      clear_frame();
      parsed_words.delete();
    end else begin
      if (cfg_we) station_mac = cfg_wdata;
      if (in_valid && !in_stall) parse_byte(in_data);
      if (out_valid && !out_stall) check_word(out_data);
    end
    waiting <= parsed_words.size();
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import erfp_pkg::*;

  typedef enum int {
    FLAW_NONE,
    FLAW_FCS,
    FLAW_PREAMBLE,
    FLAW_CUT,
    FLAW_NOISE
  } frame_flaw_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_data;
  logic        cfg_we;
  logic [47:0] cfg_wdata;
  int          fail_count;
  int          open_count;

  bit          tx_quiet;
  bit          rx_quiet;
  bit          hold_pending;
  int          items_sent;
  logic [47:0] station;

  ethernet_rx_frame_parser_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  erfp_frame_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin : rx_side
    int n;
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_pending && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end
      n = rx_quiet ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic logic [31:0] fcs_accum(logic [31:0] crc, logic [7:0] b);
    logic [31:0] v;
    v = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_GEN_REFL) : (v >> 1);
    end
    return v;
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int n;
    n = tx_quiet ? 0 : $urandom_range(0, 12);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, last_byte: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_frame(ref logic [7:0] fb[$]);
    foreach (fb[i]) send_byte(fb[i], i == fb.size() - 1);
  endtask

  task automatic build_frame(ref logic [7:0] fb[$], input logic [47:0] dst,
                             input int plen, input frame_flaw_t flaw);
    logic [31:0] crc;
    int          n;
    int          k;
    fb.delete();
    repeat (7) fb.insert(fb.size(), PREAMBLE_BYTE);
    fb.insert(fb.size(), SFD_BYTE);
    for (int i = 0; i < 6; i++) fb.insert(fb.size(), dst[47 - 8 * i -: 8]);
    repeat (8 + plen) fb.insert(fb.size(), 8'($urandom));
    crc = CRC_PRESET;
    for (int i = 8; i < fb.size(); i++) crc = fcs_accum(crc, fb[i]);
    crc = ~crc;
    for (int i = 0; i < 4; i++) fb.insert(fb.size(), crc[8 * i +: 8]);
    case (flaw)
      FLAW_FCS: begin
        k = $urandom_range(8, fb.size() - 1);
        fb[k] = fb[k] ^ (8'h01 << $urandom_range(0, 7));
      end
      FLAW_PREAMBLE: begin
        k = $urandom_range(0, 7);
        fb[k] = fb[k] ^ (8'h01 << $urandom_range(0, 7));
      end
      FLAW_CUT: begin
        n = $urandom_range(1, fb.size() - 1);
        while (fb.size() > n) void'(fb.pop_back());
      end
      FLAW_NOISE: begin
        fb.delete();
        n = $urandom_range(1, 60);
        repeat (n) fb.insert(fb.size(), 8'($urandom));
      end
      default: begin
      end
    endcase
  endtask

  task automatic write_station(logic [47:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    station = v;
  endtask

  task automatic end_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_random(int target);
    logic [7:0]  fb[$];
    logic [47:0] dst;
    frame_flaw_t flaw;
    int          pick;
    int          plen;
    int          start;
    start = items_sent;
    while (items_sent - start < target) begin
      tx_quiet = ($urandom_range(0, 7) == 0);
      rx_quiet = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 3))
        0: dst = station;
        1: dst = BROADCAST_MAC;
        2: dst = 48'({$urandom, $urandom});
        default: dst = station ^ (48'h1 << $urandom_range(0, 47));
      endcase
      plen = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 300) : $urandom_range(0, 40);
      pick = $urandom_range(0, 99);
      if (pick < 60) flaw = FLAW_NONE;
      else if (pick < 70) flaw = FLAW_FCS;
      else if (pick < 78) flaw = FLAW_PREAMBLE;
      else if (pick < 92) flaw = FLAW_CUT;
      else flaw = FLAW_NOISE;
      build_frame(fb, dst, plen, flaw);
      send_frame(fb);
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] fb[$];
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    items_sent = 0;
    station = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames
    write_station(48'({$urandom, $urandom}));
    fb = '{8'h00};
    send_frame(fb);
    fb = '{8'hff};
    send_frame(fb);
    fb = '{8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'hd5};
    send_frame(fb);
    build_frame(fb, station, 0, FLAW_NONE);
    send_frame(fb);
    build_frame(fb, BROADCAST_MAC, 1, FLAW_NONE);
    send_frame(fb);
    build_frame(fb, ~station, 2, FLAW_NONE);
    send_frame(fb);
    end_phase();

    write_station('0);
    run_random(460);
    end_phase();

    write_station('1);
    hold_pending = 1'b1;
    run_random(460);
    end_phase();

    write_station(48'({$urandom, $urandom}));
    run_random(460);
    end_phase();

    write_station(48'h8000_0000_0001);
    run_random(400);
    end_phase();

    if (fail_count == 0 && open_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/erfp_pkg.sv
rtl/core/erfp_out_queue.sv
rtl/core/ethernet_rx_frame_parser_unit.sv
verif/erfp_frame_checker.sv
verif/tb_top.sv
